// File: hdl/text_console_writer_macros.svh
// Assertion macros used by the console writer top level.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TCW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("console writer check failed");

// Next-cycle implication, checked outside reset.
`define TCW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("console writer check failed");

// Next-cycle implication that also covers reset cycles.
`define TCW_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("console writer check failed");

`endif

// File: hdl/tcw_pkg.sv
// Types and constants shared by the console writer modules.
package tcw_pkg;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] char_code;
    logic [6:0] column;
    logic [4:0] row;
    logic       use_own_attribute;
    logic [7:0] attribute;
  } cmd_t;

  typedef struct packed {
    logic [10:0] cursor_index;
    logic [15:0] cell_word;
  } rsp_t;

  typedef struct packed {
    logic ready;
    logic done;
  } eng_status_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_FILL,
    ST_SCROLL,
    ST_DRAIN,
    ST_READ,
    ST_RESP
  } state_t;

  localparam logic [2:0] KIND_PUT        = 3'd0;
  localparam logic [2:0] KIND_SETPOS     = 3'd1;
  localparam logic [2:0] KIND_CLR_SCREEN = 3'd2;
  localparam logic [2:0] KIND_CLR_ROW    = 3'd3;
  localparam logic [2:0] KIND_READ       = 3'd4;

  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_BLANK     = 8'h20;

  localparam logic [7:0] RESET_ATTR = 8'h07;

  // wide enough for row * COLUMNS + column at the largest geometry
  localparam int IDX_W = 12;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [0:0] REG_DEFAULT_ATTR = 1'b0;

endpackage

// File: hdl/text_console_writer.sv
// Text console writer top level: config register, request and response channels.
//
// Character-cell console kept in a ROWS x COLUMNS screen RAM (16-bit cells:
// character low byte, attribute high byte) with a cursor. One request is
// worked on at a time and gives one response carrying the cursor index.
// After reset a clearing pass writes blanks (attribute 7) over the whole
// screen while cmd_stall stays high.
// Put char, set position and unused kinds go straight to the response; read
// cell first reads the screen RAM; clear row and clear screen first run a fill
// pass over the row or the whole screen. A put char that scrolls also moves
// the rows up and blanks the bottom row: each goes through the single write
// port of the screen RAM, one cell per cycle. A new request may be accepted
// while the previous response waits in the output register.
`include "text_console_writer_macros.svh"

module text_console_writer #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_stall,
  input  tcw_pkg::cmd_t                     cmd,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output tcw_pkg::rsp_t                     rsp,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tcw_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [tcw_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [tcw_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  logic                 default_attr;
  logic [7:0]           attr_reg;
  logic                 cmd_fire;
  logic                 rsp_take;
  tcw_pkg::eng_status_t eng_st;
  tcw_pkg::rsp_t        eng_rsp;

  // register select: byte address 4*i
  assign default_attr = (paddr[2] == tcw_pkg::REG_DEFAULT_ATTR);

  always_ff @(posedge clk) begin
    if (rst) begin
      attr_reg <= tcw_pkg::RESET_ATTR;
    end else if (psel && penable && pwrite && default_attr) begin
      attr_reg <= pwdata[7:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = default_attr ? {24'd0, attr_reg} : '0;

  assign cmd_stall = !eng_st.ready;
  assign cmd_fire  = cmd_valid && eng_st.ready;
  assign rsp_take  = eng_st.done && (!rsp_valid || !rsp_stall);

  tcw_engine #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .TAB_STOP(TAB_STOP)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .cmd_fire    (cmd_fire),
    .cmd         (cmd),
    .default_attr(attr_reg),
    .rsp_take    (rsp_take),
    .status      (eng_st),
    .result      (eng_rsp)
  );

  // output register parts the engine from the response consumer
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_take) begin
      rsp <= eng_rsp;
    end
  end

  `TCW_ASSERT_NEXT_ALWAYS(a_stall_after_reset, rst, cmd_stall)
  `TCW_ASSERT_NEXT(a_one_at_a_time, cmd_valid && !cmd_stall, cmd_stall)
  `TCW_ASSERT_NEXT(a_result_held, eng_st.done && !rsp_take, eng_st.done)
  `TCW_ASSERT_NOW(a_no_accept_while_done, eng_st.done, cmd_stall)

endmodule

// File: hdl/tcw_ram.sv
// Generic simple dual-port RAM with registered read.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/tcw_engine.sv
// Command sequencer: cursor, screen RAM access, fills and scrolls.
module tcw_engine #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_fire,
  input  tcw_pkg::cmd_t       cmd,
  input  logic [7:0]          default_attr,
  input  logic                rsp_take,
  output tcw_pkg::eng_status_t status,
  output tcw_pkg::rsp_t       result
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int MOVE  = (ROWS - 1) * COLUMNS;
  localparam int IW    = tcw_pkg::IDX_W;

  tcw_pkg::state_t state, state_next;

  logic [4:0]    cur_row;
  logic [6:0]    cur_col;
  logic [AW-1:0] fill_addr;
  logic [AW-1:0] fill_last;
  logic [15:0]   fill_val;
  logic [AW-1:0] scr_idx;
  logic          mv_pend;
  logic [AW-1:0] mv_addr;
  logic [15:0]   res_cell;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  logic [7:0]    attr_act;
  logic [5:0]    pc_row;
  logic [7:0]    pc_col;
  logic          pc_write;
  logic [7:0]    pc_char;
  logic          pc_scroll;
  logic [4:0]    pc_wrow;
  logic [6:0]    pc_wcol;
  logic [4:0]    a_row;
  logic [6:0]    a_col;
  logic [IW-1:0] addr_full;
  logic [AW-1:0] a_addr;
  logic [IW-1:0] cur_idx;
  logic          pos_ok;
  logic          row_ok;

  // next tab stop for every column value
  logic [7:0] tab_next [128];
  for (genvar c = 0; c < 128; c++) begin : g_tab
    assign tab_next[c] = 8'(c + TAB_STOP - (c % TAB_STOP));
  end

  tcw_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_screen (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign attr_act = cmd.use_own_attribute ? cmd.attribute : default_attr;
  assign pos_ok   = (cmd.column < 7'(COLUMNS)) && (cmd.row < 5'(ROWS));
  assign row_ok   = cmd.row < 5'(ROWS);

  // cursor motion for put char, including wrap and scroll detection
  always_comb begin
    pc_row    = {1'b0, cur_row};
    pc_col    = {1'b0, cur_col};
    pc_write  = 1'b0;
    pc_char   = cmd.char_code;
    pc_scroll = 1'b0;
    pc_wrow   = cur_row;
    pc_wcol   = cur_col;
    case (cmd.char_code)
      tcw_pkg::CH_NEWLINE: begin
        pc_col = 8'd0;
        pc_row = pc_row + 6'd1;
      end
      tcw_pkg::CH_RETURN: begin
        pc_col = 8'd0;
      end
      tcw_pkg::CH_TAB: begin
        pc_col = tab_next[cur_col];
      end
      tcw_pkg::CH_BACKSPACE: begin
        if (cur_col != 7'd0) begin
          pc_col = pc_col - 8'd1;
        end else if (cur_row != 5'd0) begin
          pc_row = pc_row - 6'd1;
          pc_col = 8'(COLUMNS - 1);
        end
        pc_write = 1'b1;
        pc_char  = tcw_pkg::CH_BLANK;
        pc_wrow  = pc_row[4:0];
        pc_wcol  = pc_col[6:0];
      end
      default: begin
        pc_write = 1'b1;
        pc_col   = pc_col + 8'd1;
      end
    endcase
    if (pc_col >= 8'(COLUMNS)) begin
      pc_col = 8'd0;
      pc_row = pc_row + 6'd1;
    end
    if (pc_row >= 6'(ROWS)) begin
      pc_scroll = 1'b1;
      pc_row    = 6'(ROWS - 1);
    end
  end

  // one cell address per command: write, read or row start
  always_comb begin
    case (cmd.kind)
      tcw_pkg::KIND_PUT: begin
        a_row = pc_wrow;
        a_col = pc_wcol;
      end
      tcw_pkg::KIND_CLR_ROW: begin
        a_row = cmd.row;
        a_col = 7'd0;
      end
      default: begin
        a_row = cmd.row;
        a_col = cmd.column;
      end
    endcase
  end

  assign addr_full = IW'(a_row) * IW'(COLUMNS) + IW'(a_col);
  assign a_addr    = AW'(addr_full);
  assign cur_idx   = IW'(cur_row) * IW'(COLUMNS) + IW'(cur_col);

  // next state and RAM port control
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = fill_addr;
    ram_wdata  = fill_val;
    ram_raddr  = a_addr;
    // scroll move lands in the cycle after its read
    if (mv_pend) begin
      ram_we    = 1'b1;
      ram_waddr = mv_addr;
      ram_wdata = ram_rdata;
    end
    case (state)
      tcw_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = fill_addr;
        ram_wdata = {tcw_pkg::RESET_ATTR, tcw_pkg::CH_BLANK};
        if (fill_addr == fill_last) begin
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (cmd_fire) begin
          case (cmd.kind)
            tcw_pkg::KIND_PUT: begin
              if (pc_write) begin
                ram_we    = 1'b1;
                ram_waddr = a_addr;
                ram_wdata = {attr_act, pc_char};
              end
              state_next = pc_scroll ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_RESP;
            end
            tcw_pkg::KIND_CLR_SCREEN: state_next = tcw_pkg::ST_FILL;
            tcw_pkg::KIND_CLR_ROW:
              state_next = row_ok ? tcw_pkg::ST_FILL : tcw_pkg::ST_RESP;
            tcw_pkg::KIND_READ:
              state_next = pos_ok ? tcw_pkg::ST_READ : tcw_pkg::ST_RESP;
            default: state_next = tcw_pkg::ST_RESP;
          endcase
        end
      end
      tcw_pkg::ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_addr;
        ram_wdata = fill_val;
        if (fill_addr == fill_last) begin
          state_next = tcw_pkg::ST_RESP;
        end
      end
      tcw_pkg::ST_SCROLL: begin
        ram_raddr = scr_idx + AW'(COLUMNS);
        if (scr_idx == AW'(MOVE - 1)) begin
          state_next = tcw_pkg::ST_DRAIN;
        end
      end
      tcw_pkg::ST_DRAIN: state_next = tcw_pkg::ST_FILL;
      tcw_pkg::ST_READ:  state_next = tcw_pkg::ST_RESP;
      tcw_pkg::ST_RESP: begin
        if (rsp_take) begin
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      default: state_next = tcw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcw_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mv_pend   <= 1'b0;
      fill_addr <= '0;
      fill_last <= AW'(CELLS - 1);
      cur_row   <= 5'd0;
      cur_col   <= 7'd0;
    end else begin
      mv_pend <= (state == tcw_pkg::ST_SCROLL);
      if (state == tcw_pkg::ST_INIT || state == tcw_pkg::ST_FILL) begin
        fill_addr <= fill_addr + AW'(1);
      end
      if (state == tcw_pkg::ST_DRAIN) begin
        fill_addr <= AW'(MOVE);
        fill_last <= AW'(CELLS - 1);
      end
      if (cmd_fire) begin
        case (cmd.kind)
          tcw_pkg::KIND_PUT: begin
            cur_row <= pc_row[4:0];
            cur_col <= pc_col[6:0];
          end
          tcw_pkg::KIND_SETPOS: begin
            if (pos_ok) begin
              cur_row <= cmd.row;
              cur_col <= cmd.column;
            end
          end
          tcw_pkg::KIND_CLR_SCREEN: begin
            cur_row   <= 5'd0;
            cur_col   <= 7'd0;
            fill_addr <= '0;
            fill_last <= AW'(CELLS - 1);
          end
          tcw_pkg::KIND_CLR_ROW: begin
            if (row_ok) begin
              cur_row <= cmd.row;
              cur_col <= 7'd0;
            end
            fill_addr <= a_addr;
            fill_last <= a_addr + AW'(COLUMNS - 1);
          end
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mv_addr <= scr_idx;
    if (state == tcw_pkg::ST_SCROLL) begin
      scr_idx <= scr_idx + AW'(1);
    end
    if (state == tcw_pkg::ST_READ) begin
      res_cell <= ram_rdata;
    end
    if (cmd_fire) begin
      res_cell <= 16'd0;
      scr_idx  <= '0;
      if (cmd.kind == tcw_pkg::KIND_PUT) begin
        fill_val <= {attr_act, tcw_pkg::CH_BLANK};
      end else begin
        fill_val <= {default_attr, tcw_pkg::CH_BLANK};
      end
    end
  end

  assign status.ready        = (state == tcw_pkg::ST_IDLE);
  assign status.done         = (state == tcw_pkg::ST_RESP);
  assign result.cursor_index = cur_idx[10:0];
  assign result.cell_word    = res_cell;

endmodule

// File: tb/text_console_writer_test.sv
// Self-checking testbench for the text console writer: screen mirror, stimulus and checks.
`timescale 1ns / 1ps

localparam int CON_COLS  = 80;
localparam int CON_ROWS  = 25;
localparam int CON_TAB   = 4;
localparam int CON_CELLS = CON_COLS * CON_ROWS;

localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

// Mirrors the screen, cursor and default attribute; keeps the responses still owed.
class screen_mirror;
  logic [15:0]    cells [CON_CELLS];
  int             row_pos;
  int             col_pos;
  logic [7:0]     attr;
  tcw_pkg::rsp_t  due_reports [$];
  int             mismatches;
  int             scrolls;
  int             reads;

  function new();
    foreach (cells[i]) cells[i] = {tcw_pkg::RESET_ATTR, tcw_pkg::CH_BLANK};
    row_pos = 0;
    col_pos = 0;
    attr = tcw_pkg::RESET_ATTR;
    mismatches = 0;
    scrolls = 0;
    reads = 0;
  endfunction

  function void apply_request(tcw_pkg::cmd_t c);
    tcw_pkg::rsp_t r;
    logic [7:0]    a;
    r.cell_word = '0;
    case (c.kind)
      tcw_pkg::KIND_PUT: begin
        a = c.use_own_attribute ? c.attribute : attr;
        case (c.char_code)
          tcw_pkg::CH_NEWLINE: begin
            col_pos = 0;
            row_pos++;
          end
          tcw_pkg::CH_RETURN: col_pos = 0;
          tcw_pkg::CH_TAB: col_pos = col_pos + CON_TAB - (col_pos % CON_TAB);
          tcw_pkg::CH_BACKSPACE: begin
            if (col_pos > 0) begin
              col_pos--;
            end else if (row_pos > 0) begin
              row_pos--;
              col_pos = CON_COLS - 1;
            end
            cells[row_pos * CON_COLS + col_pos] = {a, tcw_pkg::CH_BLANK};
          end
          default: begin
            cells[row_pos * CON_COLS + col_pos] = {a, c.char_code};
            col_pos++;
          end
        endcase
        if (col_pos >= CON_COLS) begin
          col_pos = 0;
          row_pos++;
        end
        // past the bottom: shift up one row, blank the new bottom row
        if (row_pos >= CON_ROWS) begin
          for (int i = 0; i < (CON_ROWS - 1) * CON_COLS; i++) cells[i] = cells[i + CON_COLS];
          for (int i = (CON_ROWS - 1) * CON_COLS; i < CON_CELLS; i++)
            cells[i] = {a, tcw_pkg::CH_BLANK};
          row_pos = CON_ROWS - 1;
          scrolls++;
        end
      end
      tcw_pkg::KIND_SETPOS: begin
        if (c.column < CON_COLS && c.row < CON_ROWS) begin
          row_pos = int'(c.row);
          col_pos = int'(c.column);
        end
      end
      tcw_pkg::KIND_CLR_SCREEN: begin
        foreach (cells[i]) cells[i] = {attr, tcw_pkg::CH_BLANK};
        row_pos = 0;
        col_pos = 0;
      end
      tcw_pkg::KIND_CLR_ROW: begin
        if (c.row < CON_ROWS) begin
          for (int i = 0; i < CON_COLS; i++)
            cells[int'(c.row) * CON_COLS + i] = {attr, tcw_pkg::CH_BLANK};
          row_pos = int'(c.row);
          col_pos = 0;
        end
      end
      tcw_pkg::KIND_READ: begin
        reads++;
        if (c.column < CON_COLS && c.row < CON_ROWS)
          r.cell_word = cells[int'(c.row) * CON_COLS + int'(c.column)];
      end
      default: ;
    endcase
    r.cursor_index = 11'(row_pos * CON_COLS + col_pos);
    due_reports.push_back(r);
  endfunction

  function void check_response(tcw_pkg::rsp_t got);
    tcw_pkg::rsp_t want;
    if (due_reports.size() == 0) begin
      $display("%0t: response with none expected: cursor_index %0d cell_word %h",
               $time, got.cursor_index, got.cell_word);
      mismatches++;
      return;
    end
    want = due_reports.pop_front();
    if (got.cursor_index !== want.cursor_index) begin
      $display("%0t: cursor_index expected %0d got %0d", $time, want.cursor_index,
               got.cursor_index);
      mismatches++;
    end
    if (got.cell_word !== want.cell_word) begin
      $display("%0t: cell_word expected %h got %h", $time, want.cell_word, got.cell_word);
      mismatches++;
    end
  endfunction
endclass

module text_console_writer_test;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_ITEMS = 140;
  localparam int ADDR_W = tcw_pkg::APB_ADDR_W;
  localparam int DATA_W = tcw_pkg::APB_DATA_W;
  localparam logic [ADDR_W-1:0] ATTR_ADDR = ADDR_W'(4 * tcw_pkg::REG_DEFAULT_ATTR);

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cmd_valid;
  logic                  cmd_stall;
  tcw_pkg::cmd_t         cmd;
  logic                  rsp_valid;
  logic                  rsp_stall;
  tcw_pkg::rsp_t         rsp;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [DATA_W-1:0]     pwdata;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;

  screen_mirror sb = new();
  bit           no_idle = 1'b0;
  bit           hold_off_req = 1'b0;
  int           stuck_cycles = 0;
  int           sent = 0;
  int           settings_used = 0;

  text_console_writer #(
    .COLUMNS(CON_COLS),
    .ROWS(CON_ROWS),
    .TAB_STOP(CON_TAB)
  ) DUT (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // monitor: mirror accepted requests, check accepted responses, watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && !cmd_stall) sb.apply_request(cmd);
      if (rsp_valid && !rsp_stall) sb.check_response(rsp);
      if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog: no progress for %0d cycles", $time, stuck_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // response side: random stalls, or a long hold-off when asked
  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        rsp_stall = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      rsp_stall = !no_idle && ($urandom_range(99) < 8);
    end
  end

  function automatic tcw_pkg::cmd_t mk(logic [2:0] kind, logic [7:0] ch, logic [6:0] col,
                                       logic [4:0] row, logic own, logic [7:0] attr);
    tcw_pkg::cmd_t c;
    c.kind = kind;
    c.char_code = ch;
    c.column = col;
    c.row = row;
    c.use_own_attribute = own;
    c.attribute = attr;
    return c;
  endfunction

  function automatic tcw_pkg::cmd_t random_put();
    tcw_pkg::cmd_t c;
    int            r;
    c = tcw_pkg::cmd_t'($urandom);
    c.kind = tcw_pkg::KIND_PUT;
    r = $urandom_range(99);
    if (r < 8) c.char_code = tcw_pkg::CH_NEWLINE;
    else if (r < 13) c.char_code = tcw_pkg::CH_RETURN;
    else if (r < 21) c.char_code = tcw_pkg::CH_TAB;
    else if (r < 30) c.char_code = tcw_pkg::CH_BACKSPACE;
    return c;
  endfunction

  // noise: any field value, kinds weighted so clear screen stays rare
  function automatic tcw_pkg::cmd_t random_single();
    tcw_pkg::cmd_t c;
    int            r;
    c = tcw_pkg::cmd_t'($urandom);
    r = $urandom_range(99);
    if (r < 30) c.kind = tcw_pkg::KIND_PUT;
    else if (r < 50) c.kind = tcw_pkg::KIND_SETPOS;
    else if (r < 58) c.kind = tcw_pkg::KIND_CLR_ROW;
    else if (r < 83) c.kind = tcw_pkg::KIND_READ;
    else if (r < 88) c.kind = tcw_pkg::KIND_CLR_SCREEN;
    else c.kind = 3'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
    return c;
  endfunction

  task automatic send_request(input tcw_pkg::cmd_t c);
    if (!no_idle) begin
      while ($urandom_range(99) < 8) begin
        cmd_valid = 1'b0;
        @(negedge clk);
      end
    end
    cmd = c;
    cmd_valid = 1'b1;
    do @(posedge clk); while (cmd_stall);
    @(negedge clk);
    sent++;
  endtask

  task automatic drain();
    cmd_valid = 1'b0;
    while (sb.due_reports.size() != 0) @(negedge clk);
  endtask

  // write the default attribute, then read it back
  task automatic write_attribute(input logic [7:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = ATTR_ADDR;
    pwdata = DATA_W'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.attr = value;
    settings_used++;
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== value) begin
      $display("%0t: default_attribute expected %h got %h", $time, value, prdata[7:0]);
      sb.mismatches++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // mostly typing bursts from a placed cursor with read-back, plus noise
  task automatic run_phase(input int count);
    int            left;
    tcw_pkg::cmd_t c;
    left = count;
    while (left > 0) begin
      if ($urandom_range(99) < 60) begin
        c = tcw_pkg::cmd_t'($urandom);
        c.kind = tcw_pkg::KIND_SETPOS;
        if ($urandom_range(3) == 0) begin
          c.row = 5'(CON_ROWS - 1);
          c.column = 7'($urandom_range(CON_COLS - 1, CON_COLS - 6));
        end else begin
          c.row = 5'($urandom_range(CON_ROWS - 1));
          c.column = 7'($urandom_range(CON_COLS - 1));
        end
        send_request(c);
        left--;
        repeat ($urandom_range(10, 2)) begin
          send_request(random_put());
          left--;
        end
        repeat ($urandom_range(3)) begin
          c = tcw_pkg::cmd_t'($urandom);
          c.kind = tcw_pkg::KIND_READ;
          if ($urandom_range(1) == 0) begin
            c.row = 5'(sb.row_pos);
            c.column = 7'($urandom_range(sb.col_pos));
          end else begin
            c.row = 5'($urandom_range(CON_ROWS - 1));
            c.column = 7'($urandom_range(CON_COLS - 1));
          end
          send_request(c);
          left--;
        end
      end else begin
        send_request(random_single());
        left--;
      end
    end
  endtask

  initial begin
    logic [7:0] phase_attr [5];
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: field extremes, control characters, wraps, scrolls, range checks
    send_request(mk(tcw_pkg::KIND_READ, 8'h00, 7'd0, 5'd0, 1'b0, 8'h00));
    send_request(mk(tcw_pkg::KIND_PUT, 8'h41, 7'd0, 5'd0, 1'b1, 8'hFF));
    send_request(mk(tcw_pkg::KIND_PUT, 8'h00, 7'd0, 5'd0, 1'b0, 8'hFF));
    send_request(mk(tcw_pkg::KIND_PUT, 8'hFF, 7'd127, 5'd31, 1'b1, 8'h00));
    send_request(mk(tcw_pkg::KIND_PUT, tcw_pkg::CH_TAB, 7'd0, 5'd0, 1'b0, 8'h00));
    send_request(mk(tcw_pkg::KIND_PUT, tcw_pkg::CH_BACKSPACE, 7'd0, 5'd0, 1'b1, 8'h3C));
    send_request(mk(tcw_pkg::KIND_PUT, tcw_pkg::CH_RETURN, 7'd0, 5'd0, 1'b0, 8'h00));
    send_request(mk(tcw_pkg::KIND_SETPOS, 8'h00, 7'd79, 5'd0, 1'b0, 8'h00));
    send_request(mk(tcw_pkg::KIND_PUT, 8'h78, 7'd0, 5'd0, 1'b0, 8'h00));
    send_request(mk(tcw_pkg::KIND_PUT, tcw_pkg::CH_BACKSPACE, 7'd0, 5'd0, 1'b0, 8'h00));
    send_request(mk(tcw_pkg::KIND_SETPOS, 8'h00, 7'd0, 5'd0, 1'b0, 8'h00));
    send_request(mk(tcw_pkg::KIND_PUT, tcw_pkg::CH_BACKSPACE, 7'd0, 5'd0, 1'b0, 8'h00));
    send_request(mk(tcw_pkg::KIND_SETPOS, 8'hFF, 7'd127, 5'd31, 1'b1, 8'hFF));
    send_request(mk(tcw_pkg::KIND_SETPOS, 8'h00, 7'd80, 5'd0, 1'b0, 8'h00));
    send_request(mk(tcw_pkg::KIND_SETPOS, 8'h00, 7'd0, 5'd25, 1'b0, 8'h00));
    // tab off the end of the bottom row scrolls with the item's attribute
    send_request(mk(tcw_pkg::KIND_SETPOS, 8'h00, 7'd78, 5'd24, 1'b0, 8'h00));
    send_request(mk(tcw_pkg::KIND_PUT, tcw_pkg::CH_TAB, 7'd0, 5'd0, 1'b1, 8'h5A));
    send_request(mk(tcw_pkg::KIND_READ, 8'h00, 7'd0, 5'd24, 1'b0, 8'h00));
    send_request(mk(tcw_pkg::KIND_PUT, tcw_pkg::CH_NEWLINE, 7'd0, 5'd0, 1'b0, 8'h00));
    send_request(mk(tcw_pkg::KIND_READ, 8'h00, 7'd79, 5'd24, 1'b0, 8'h00));
    send_request(mk(tcw_pkg::KIND_READ, 8'hFF, 7'd127, 5'd31, 1'b1, 8'hFF));
    send_request(mk(tcw_pkg::KIND_CLR_ROW, 8'h00, 7'd0, 5'd31, 1'b0, 8'h00));
    send_request(mk(tcw_pkg::KIND_CLR_ROW, 8'h00, 7'd5, 5'd23, 1'b0, 8'h00));
    for (int k = int'(KIND_UNUSED_LO); k <= int'(KIND_UNUSED_HI); k++)
      send_request(mk(3'(k), 8'hFF, 7'd127, 5'd31, 1'b1, 8'hFF));
    send_request(mk(tcw_pkg::KIND_CLR_SCREEN, 8'h00, 7'd0, 5'd0, 1'b0, 8'h00));
    send_request(mk(tcw_pkg::KIND_READ, 8'h00, 7'd0, 5'd0, 1'b0, 8'h00));

    phase_attr[0] = 8'h00;
    phase_attr[1] = 8'hFF;
    phase_attr[2] = 8'($urandom);
    phase_attr[3] = 8'($urandom);
    phase_attr[4] = tcw_pkg::RESET_ATTR;
    for (int p = 0; p < 5; p++) begin
      drain();
      write_attribute(phase_attr[p]);
      // second phase: receiver holds off so the block backs up
      if (p == 1) hold_off_req = 1'b1;
      no_idle = (p == 3);
      run_phase(PHASE_ITEMS);
      no_idle = 1'b0;
    end
    drain();
    repeat (10) @(posedge clk);

    $display("Covered %0d requests under %0d attribute settings: %0d scrolls, %0d cell reads.",
             sent, settings_used, sb.scrolls, sb.reads);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
